>>> sv/scanline_sprite_mapper_unit_macros.svh
`ifndef SCANLINE_SPRITE_MAPPER_UNIT_MACROS_SVH
`define SCANLINE_SPRITE_MAPPER_UNIT_MACROS_SVH

// Checks that hold in the same cycle.
`define SSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanline sprite mapper check failed");

// Checks that hold in the next cycle.
`define SSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanline sprite mapper check failed");

`endif

>>> sv/ssm_pkg.sv
package ssm_pkg;

   localparam int KIND_W      = 2;
   localparam int SPRITE_W    = 6;
   localparam int Y_W         = 8;
   localparam int LINE_IN_W   = 8;
   localparam int SLOT_W      = 4;
   localparam int COUNT_OUT_W = 4;

   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam int SHORT_HEIGHT = 8;
   localparam int TALL_HEIGHT  = 16;
   localparam int Y_OFFSET     = 16;
   localparam int SPAN_BIAS    = 17;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic           hit;
      logic [Y_W-1:0] first;
      logic [Y_W-1:0] last;
   } span_type;

endpackage

>>> sv/scanline_sprite_mapper_unit.sv
// Keeps a list of up to MAX_PER_LINE sprite numbers for each display line. A clear item
// empties all lists; a read item returns one list entry and the line's count. An add item
// visits every line the sprite covers, clipped to the visible lines: the line-count
// memory has a single read and a single write port, so the add issues one count read per
// cycle and writes the updated count and the list entry in the next cycle. A finished
// result waits in the output register while the next item is accepted. There is no
// clearing pass after reset.
`include "scanline_sprite_mapper_unit_macros.svh"

module scanline_sprite_mapper_unit #(
   parameter int VISIBLE_LINES = 144,
   parameter int MAX_PER_LINE  = 10,
   parameter int SPRITE_COUNT  = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ssm_pkg::KIND_W-1:0]      req_kind,
   input  logic [ssm_pkg::SPRITE_W-1:0]    req_sprite_number,
   input  logic [ssm_pkg::Y_W-1:0]         req_y_position,
   input  logic                            req_tall,
   input  logic [ssm_pkg::LINE_IN_W-1:0]   req_line,
   input  logic [ssm_pkg::SLOT_W-1:0]      req_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssm_pkg::SPRITE_W-1:0]    rsp_entry_sprite,
   output logic [ssm_pkg::COUNT_OUT_W-1:0] rsp_line_count,
   output logic                            rsp_entry_valid
);
   import ssm_pkg::*;

   localparam int LINE_W    = (VISIBLE_LINES > 1) ? $clog2(VISIBLE_LINES) : 1;
   localparam int CNT_W     = $clog2(MAX_PER_LINE + 1);
   localparam int TAB_DEPTH = VISIBLE_LINES * MAX_PER_LINE;
   localparam int TAB_W     = $clog2(TAB_DEPTH);

   state_type state_ff, state_in;
   span_type  span;

   logic [VISIBLE_LINES-1:0] lv_ff, lv_in;
   logic                     more_ff, more_in;
   logic                     pend_ff, pend_in;
   logic [LINE_W-1:0]        cur_ff, cur_in;
   logic [LINE_W-1:0]        last_ff, last_in;
   logic [LINE_W-1:0]        pend_line_ff, pend_line_in;
   logic [SPRITE_W-1:0]      num_ff, num_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic                     rd_lv_ff, rd_lv_in;
   logic [SLOT_W-1:0]        rd_slot_ff, rd_slot_in;
   logic [SPRITE_W-1:0]      res_sprite_ff, res_sprite_in;
   logic [COUNT_OUT_W-1:0]   res_count_ff, res_count_in;
   logic                     res_valid_ff, res_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SPRITE_W-1:0]      rsp_sprite_ff, rsp_sprite_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_ev_ff, rsp_ev_in;

   logic [CNT_W-1:0]    cnt_mem_ff [VISIBLE_LINES];
   logic [SPRITE_W-1:0] tab_mem_ff [TAB_DEPTH];
   logic [CNT_W-1:0]    cnt_q_ff;
   logic [SPRITE_W-1:0] tab_q_ff;

   logic [LINE_W-1:0]   cnt_raddr;
   logic [TAB_W-1:0]    tab_raddr;
   logic                cnt_we;
   logic [LINE_W-1:0]   cnt_waddr;
   logic [CNT_W-1:0]    cnt_wdata;
   logic                tab_we;
   logic [TAB_W-1:0]    tab_waddr;
   logic [SPRITE_W-1:0] tab_wdata;
   logic [CNT_W-1:0]    cnt_cur;
   logic                line_ok;

   ssm_span #(
      .VISIBLE_LINES(VISIBLE_LINES),
      .SPRITE_COUNT (SPRITE_COUNT)
   ) u_span (
      .sprite_number(req_sprite_number),
      .y_position   (req_y_position),
      .tall         (req_tall),
      .span         (span)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_sprite = rsp_sprite_ff;
   assign rsp_line_count   = rsp_count_ff;
   assign rsp_entry_valid  = rsp_ev_ff;

   always_comb begin
      state_in      = state_ff;
      lv_in         = lv_ff;
      more_in       = more_ff;
      pend_in       = 1'b0;
      cur_in        = cur_ff;
      last_in       = last_ff;
      pend_line_in  = cur_ff;
      num_in        = num_ff;
      rd_ok_in      = rd_ok_ff;
      rd_lv_in      = rd_lv_ff;
      rd_slot_in    = rd_slot_ff;
      res_sprite_in = res_sprite_ff;
      res_count_in  = res_count_ff;
      res_valid_in  = res_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sprite_in = rsp_sprite_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ev_in     = rsp_ev_ff;
      cnt_raddr     = cur_ff;
      tab_raddr     = TAB_W'(TAB_W'(req_line) * TAB_W'(MAX_PER_LINE)) + TAB_W'(req_slot);
      cnt_we        = 1'b0;
      cnt_waddr     = pend_line_ff;
      cnt_wdata     = cnt_q_ff + CNT_W'(1);
      tab_we        = 1'b0;
      tab_waddr     = TAB_W'(TAB_W'(pend_line_ff) * TAB_W'(MAX_PER_LINE))
                      + TAB_W'(lv_ff[pend_line_ff] ? cnt_q_ff : '0);
      tab_wdata     = num_ff;
      cnt_cur       = '0;
      line_ok       = ({1'b0, req_line} < 9'(VISIBLE_LINES));

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_sprite_in = '0;
               res_count_in  = '0;
               res_valid_in  = 1'b0;
               state_in      = ST_DONE;
               case (req_kind)
                  KIND_CLEAR: begin
                     lv_in = '0;
                  end
                  KIND_ADD: begin
                     if (span.hit) begin
                        cur_in   = LINE_W'(span.first);
                        last_in  = LINE_W'(span.last);
                        more_in  = 1'b1;
                        num_in   = req_sprite_number;
                        state_in = ST_ADD;
                     end
                  end
                  KIND_READ: begin
                     cnt_raddr  = LINE_W'(req_line);
                     rd_ok_in   = line_ok;
                     rd_lv_in   = line_ok ? lv_ff[LINE_W'(req_line)] : 1'b0;
                     rd_slot_in = req_slot;
                     state_in   = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            if (more_ff) begin
               cnt_raddr    = cur_ff;
               pend_in      = 1'b1;
               pend_line_in = cur_ff;
               if (cur_ff == last_ff) begin
                  more_in = 1'b0;
               end else begin
                  cur_in = cur_ff + LINE_W'(1);
               end
            end else begin
               state_in = ST_DONE;
            end
            if (pend_ff) begin
               cnt_cur = lv_ff[pend_line_ff] ? cnt_q_ff : '0;
               if (cnt_cur < CNT_W'(MAX_PER_LINE)) begin
                  cnt_we              = 1'b1;
                  cnt_wdata           = cnt_cur + CNT_W'(1);
                  tab_we              = 1'b1;
                  lv_in[pend_line_ff] = 1'b1;
               end
            end
         end
         ST_READ: begin
            cnt_cur = rd_lv_ff ? cnt_q_ff : '0;
            if (rd_ok_ff) begin
               res_count_in = COUNT_OUT_W'(cnt_cur);
               if ((5'(rd_slot_ff) < 5'(MAX_PER_LINE)) && (5'(rd_slot_ff) < 5'(cnt_cur))) begin
                  res_sprite_in = tab_q_ff;
                  res_valid_in  = 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sprite_in = res_sprite_ff;
               rsp_count_in  = res_count_ff;
               rsp_ev_in     = res_valid_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lv_ff        <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lv_ff        <= lv_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      pend_line_ff  <= pend_line_in;
      num_ff        <= num_in;
      rd_ok_ff      <= rd_ok_in;
      rd_lv_ff      <= rd_lv_in;
      rd_slot_ff    <= rd_slot_in;
      res_sprite_ff <= res_sprite_in;
      res_count_ff  <= res_count_in;
      res_valid_ff  <= res_valid_in;
      rsp_sprite_ff <= rsp_sprite_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ev_ff     <= rsp_ev_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      cnt_q_ff <= cnt_mem_ff[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem_ff[tab_waddr] <= tab_wdata;
      end
      tab_q_ff <= tab_mem_ff[tab_raddr];
   end

   `SSM_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE)
   `SSM_ASSERT_IMP(a_pend_only_in_add, clock, reset, pend_ff, state_ff == ST_ADD)
   `SSM_ASSERT_IMP(a_count_bounded, clock, reset, cnt_we, cnt_wdata <= CNT_W'(MAX_PER_LINE))
   `SSM_ASSERT_NXT(a_done_delivers, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && state_ff == ST_IDLE)

endmodule

>>> sv/ssm_span.sv
module ssm_span #(
   parameter int VISIBLE_LINES = 144,
   parameter int SPRITE_COUNT  = 40
) (
   input  logic [ssm_pkg::SPRITE_W-1:0] sprite_number,
   input  logic [ssm_pkg::Y_W-1:0]      y_position,
   input  logic                         tall,
   output ssm_pkg::span_type            span
);
   import ssm_pkg::*;

   logic [4:0] height;
   logic [9:0] y_wide;
   logic [9:0] y_sum;
   logic [9:0] last_raw;
   logic       number_ok;

   always_comb begin
      height    = tall ? 5'(TALL_HEIGHT) : 5'(SHORT_HEIGHT);
      y_wide    = 10'(y_position);
      y_sum     = y_wide + 10'(height);
      last_raw  = y_sum - 10'(SPAN_BIAS);
      number_ok = 7'(sprite_number) < 7'(SPRITE_COUNT);

      span.hit = number_ok && (y_sum >= 10'(SPAN_BIAS))
                 && (y_wide < 10'(VISIBLE_LINES + Y_OFFSET));

      if (y_wide >= 10'(Y_OFFSET)) begin
         span.first = 8'(y_wide - 10'(Y_OFFSET));
      end else begin
         span.first = '0;
      end

      if (last_raw > 10'(VISIBLE_LINES - 1)) begin
         span.last = 8'(VISIBLE_LINES - 1);
      end else begin
         span.last = last_raw[7:0];
      end
   end

endmodule
